// ===== rtl/ias_pkg.sv =====
// ---------------------------------------------------------------------------
// Insertable array store package
// Shared field widths, operation codes and status codes for the store core
// and its channel interfaces.
// ---------------------------------------------------------------------------
package ias_pkg;

   // Field widths of one request item and one response item.
   localparam int POS_W   = 8;
   localparam int WORD_W  = 32;
   localparam int COUNT_W = 9;
   localparam int CODE_W  = 2;

   typedef logic [CODE_W-1:0]        mode_type;
   typedef logic [CODE_W-1:0]        status_type;
   typedef logic [POS_W-1:0]         pos_type;
   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [COUNT_W-1:0]       count_type;

   // Operation codes carried in the mode field.
   localparam mode_type MODE_APPEND = 2'd0;
   localparam mode_type MODE_INSERT = 2'd1;
   localparam mode_type MODE_READ   = 2'd2;

   // Status codes carried in the status field.
   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_RANGE = 2'd2;

   // Value returned by a read that misses the list.
   localparam word_type READ_ERR_VALUE = -32'sd1;

endpackage

// ===== rtl/ias_if.sv =====
// ---------------------------------------------------------------------------
// Insertable array store channel interfaces
// Valid/ready channels for request items and response items.
// ---------------------------------------------------------------------------
interface ias_req_if import ias_pkg::*; ();
   logic     valid;
   logic     ready;
   mode_type mode;
   pos_type  position;
   word_type value;

   modport source (output valid, output mode, output position, output value, input ready);
   modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

interface ias_rsp_if import ias_pkg::*; ();
   logic       valid;
   logic       ready;
   word_type   read_value;
   count_type  entry_count;
   status_type status;

   modport source (output valid, output read_value, output entry_count, output status,
                   input ready);
   modport sink   (input valid, input read_value, input entry_count, input status,
                   output ready);
endinterface

// ===== rtl/insertable_array_store_core.sv =====
// ---------------------------------------------------------------------------
// Insertable array store core
// Fixed-capacity ordered list of signed words with append, insert and read.
// ---------------------------------------------------------------------------
// Usage:
// Request items arrive on req_chan (mode, position, value) and each one gives
// exactly one response item on rsp_chan (read_value, entry_count, status).
// The list lives in one single-port-write, registered-read memory. A request
// is taken only while the core is idle; one item is worked on at a time.
// Append, insert at the end and every refused item pass from acceptance
// through the done state to the response register; a read also waits in a
// read-wait state for the memory. An insert inside the list moves each later
// entry up one place, one memory write per cycle, then writes the new value;
// the worst case is an insert at position zero into a list one short of full.
// A finished response sits in the output register until taken. The next
// request is accepted and worked on meanwhile; its response waits in the core
// until the output register frees up, and requests stay blocked until then.
// Reset empties the list (count zero) and drops any pending response. The
// memory contents are not cleared; only entries below the count are ever read.
// ---------------------------------------------------------------------------
module insertable_array_store_core
   import ias_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  logic      clock,
   input  logic      reset,
   ias_req_if.sink   req_chan,
   ias_rsp_if.source rsp_chan
);

   localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT,
      S_INS,
      S_RWAIT,
      S_DONE
   } state_type;

   // Entry memory.
   word_type entries_mem [CAPACITY];

   state_type      state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [AW-1:0]  pos_ff, pos_in;
   logic [AW-1:0]  wr_idx_ff, wr_idx_in;
   word_type       val_ff, val_in;
   word_type       res_value_ff, res_value_in;
   status_type     res_status_ff, res_status_in;
   logic           rsp_valid_ff, rsp_valid_in;
   word_type       rsp_value_ff, rsp_value_in;
   count_type      rsp_count_ff, rsp_count_in;
   status_type     rsp_status_ff, rsp_status_in;
   word_type       rd_data_ff;

   logic           mem_we;
   logic [AW-1:0]  mem_waddr;
   word_type       mem_wdata;
   logic [AW-1:0]  rd_addr;

   logic            req_acc;
   logic            full;
   logic [CMPW-1:0] pos_cmp;
   logic [CMPW-1:0] count_cmp;

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign req_acc              = req_chan.valid && req_chan.ready;
   assign full                 = (count_ff == CW'(CAPACITY));
   assign pos_cmp              = CMPW'(req_chan.position);
   assign count_cmp            = CMPW'(count_ff);

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.read_value  = rsp_value_ff;
   assign rsp_chan.entry_count = rsp_count_ff;
   assign rsp_chan.status      = rsp_status_ff;

   // Memory: one write port, one registered read port. Shift reads and writes
   // always target different entries, so no forwarding is needed.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entries_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= entries_mem[rd_addr];
   end

   // Next-state and datapath control.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      wr_idx_in     = wr_idx_ff;
      val_in        = val_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      rd_addr       = '0;

      // A taken response frees the output register.
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               val_in       = req_chan.value;
               res_value_in = '0;
               state_in     = S_DONE;
               case (req_chan.mode)
                  MODE_APPEND, MODE_INSERT: begin
                     if (full) begin
                        res_status_in = ST_FULL;
                     end else if (req_chan.mode == MODE_INSERT && pos_cmp > count_cmp) begin
                        res_status_in = ST_RANGE;
                     end else if (req_chan.mode == MODE_APPEND || pos_cmp == count_cmp) begin
                        // Write at the end of the list; nothing moves.
                        mem_we        = 1'b1;
                        mem_waddr     = count_ff[AW-1:0];
                        mem_wdata     = req_chan.value;
                        count_in      = count_ff + CW'(1);
                        res_status_in = ST_OK;
                     end else begin
                        // Start moving entries from the top down.
                        pos_in    = AW'(req_chan.position);
                        wr_idx_in = count_ff[AW-1:0];
                        rd_addr   = count_ff[AW-1:0] - AW'(1);
                        state_in  = S_SHIFT;
                     end
                  end
                  MODE_READ: begin
                     if (pos_cmp >= count_cmp) begin
                        res_value_in  = READ_ERR_VALUE;
                        res_status_in = ST_RANGE;
                     end else begin
                        rd_addr  = AW'(req_chan.position);
                        state_in = S_RWAIT;
                     end
                  end
                  default: begin
                     res_status_in = ST_RANGE;
                  end
               endcase
            end
         end

         S_SHIFT: begin
            // Entry below the write index arrived last cycle; move it up.
            mem_we    = 1'b1;
            mem_waddr = wr_idx_ff;
            mem_wdata = rd_data_ff;
            wr_idx_in = wr_idx_ff - AW'(1);
            if (wr_idx_ff - AW'(1) == pos_ff) begin
               state_in = S_INS;
            end else begin
               rd_addr = wr_idx_ff - AW'(2);
            end
         end

         S_INS: begin
            // The gap is open; drop the new value in.
            mem_we        = 1'b1;
            mem_waddr     = pos_ff;
            mem_wdata     = val_ff;
            count_in      = count_ff + CW'(1);
            res_value_in  = '0;
            res_status_in = ST_OK;
            state_in      = S_DONE;
         end

         S_RWAIT: begin
            res_value_in  = rd_data_ff;
            res_status_in = ST_OK;
            state_in      = S_DONE;
         end

         S_DONE: begin
            // Hand the result over once the output register is free.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_count_in  = COUNT_W'(count_ff);
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff        <= pos_in;
      wr_idx_ff     <= wr_idx_in;
      val_ff        <= val_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   // The list never holds more than its capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count exceeds capacity");

   // The count only ever grows by one entry at a time.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> (count_ff == $past(count_ff) + CW'(1)))
      else $error("entry count changed by other than one");

   // While moving entries, the write index stays above the insert position.
   a_shift_above: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (wr_idx_ff > pos_ff))
      else $error("shift walked below the insert position");

   // A new response is loaded only out of the done state.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("response raised outside the done state");

endmodule

// ===== sim/testbench.sv =====
// ---------------------------------------------------------------------------
// Insertable array store testbench
// Drives append, insert and read items into the store core and checks every
// response against a list model kept in the testbench. A short directed run
// covers the empty list, the end of the list and the unused mode. A random run
// then fills the list to capacity and keeps working on the full store. Both
// channels idle at random, and the response side holds off twice for a long
// stretch so that the core backs up into its request channel.
// ---------------------------------------------------------------------------
module testbench
   import ias_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int       CAPACITY     = 256;
   localparam int       RANDOM_OPS   = 1130;
   localparam int       LONG_HOLD    = 500;
   localparam int       DRAIN_CYCLES = 300;
   localparam int       CYCLE_LIMIT  = 1_000_000;
   localparam mode_type MODE_UNUSED  = 2'd3;

   typedef struct packed {
      mode_type mode;
      pos_type  position;
      word_type value;
   } list_op_type;

   typedef struct packed {
      word_type   read_value;
      count_type  entry_count;
      status_type status;
   } list_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ias_req_if req_bus ();
   ias_rsp_if rsp_bus ();

   insertable_array_store_core #(
      .CAPACITY(CAPACITY)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus.sink),
      .rsp_chan(rsp_bus.source)
   );

   // Stimulus and checking state.
   list_op_type    ops_to_send[$];
   list_reply_type replies_due[$];
   word_type       list_words[CAPACITY];
   int             list_count    = 0;
   int             planned_count = 0;
   int             ops_queued    = 0;
   int             ops_accepted  = 0;
   int             replies_taken = 0;
   int             error_count   = 0;
   int             cycle_count   = 0;
   bit             op_sending    = 1'b0;
   bit             op_taken      = 1'b0;
   bit             reply_taken   = 1'b0;
   int             send_wait     = 0;
   int             hold_left     = 0;

   always #2 clock = ~clock;

   // Inputs start at known values.
   initial begin
      req_bus.valid    = 1'b0;
      req_bus.mode     = MODE_APPEND;
      req_bus.position = '0;
      req_bus.value    = '0;
      rsp_bus.ready    = 1'b0;
   end

   // Wait before an item: some stretches run back to back, the rest idle at random.
   function automatic int draw_wait(int seq);
      return (seq % 97 < 25) ? 0 : $urandom_range(10, 0);
   endfunction

   // Applies one operation to the list copy and returns the response it gives.
   function automatic list_reply_type apply_list_op(list_op_type op);
      list_reply_type r;
      int             slot;
      r.read_value = '0;
      r.status     = ST_OK;
      case (op.mode)
         MODE_APPEND, MODE_INSERT: begin
            if (list_count >= CAPACITY) begin
               r.status = ST_FULL;
            end else if (op.mode == MODE_INSERT && int'(op.position) > list_count) begin
               r.status = ST_RANGE;
            end else begin
               slot = (op.mode == MODE_APPEND) ? list_count : int'(op.position);
               for (int i = list_count; i > slot; i--) begin
                  list_words[i] = list_words[i-1];
               end
               list_words[slot] = op.value;
               list_count++;
            end
         end
         MODE_READ: begin
            if (int'(op.position) >= list_count) begin
               r.read_value = READ_ERR_VALUE;
               r.status     = ST_RANGE;
            end else begin
               r.read_value = list_words[op.position];
            end
         end
         default: begin
            r.status = ST_RANGE;
         end
      endcase
      r.entry_count = count_type'(list_count);
      return r;
   endfunction

   // Queues one item and tracks the list size the stimulus will have built.
   task automatic queue_op(mode_type mode, int position, word_type value);
      list_op_type op;
      op.mode     = mode;
      op.position = pos_type'(position);
      op.value    = value;
      ops_to_send = {ops_to_send, op};
      ops_queued++;
      if (planned_count < CAPACITY &&
          (mode == MODE_APPEND || (mode == MODE_INSERT && position <= planned_count))) begin
         planned_count++;
      end
   endtask

   // Request driver: one item at a time, changed on the falling edge.
   always @(negedge clock) begin
      list_op_type op;
      if (!reset) begin
         if (op_sending && op_taken) begin
            op_sending = 1'b0;
            send_wait  = draw_wait(ops_accepted);
         end
         op_taken = 1'b0;
         if (!op_sending) begin
            if (send_wait > 0) begin
               send_wait--;
            end else if (ops_to_send.size() > 0) begin
               op = ops_to_send.pop_front();
               op_sending = 1'b1;
               req_bus.mode     <= op.mode;
               req_bus.position <= op.position;
               req_bus.value    <= op.value;
            end
         end
         req_bus.valid <= op_sending;
      end
   end

   // Request acceptance: predict the response of each accepted item.
   always @(posedge clock) begin
      list_op_type op;
      if (!reset && req_bus.valid && req_bus.ready) begin
         op.mode     = req_bus.mode;
         op.position = req_bus.position;
         op.value    = req_bus.value;
         replies_due = {replies_due, apply_list_op(op)};
         ops_accepted++;
         op_taken = 1'b1;
      end
   end

   // Response receiver: waits after each item, twice for a long stretch.
   always @(negedge clock) begin
      if (!reset) begin
         if (reply_taken) begin
            reply_taken = 1'b0;
            if (replies_taken == 60 || replies_taken == 600) begin
               hold_left = LONG_HOLD;
            end else begin
               hold_left = draw_wait(replies_taken + 40);
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Response monitor: compare each item with the oldest prediction.
   always @(posedge clock) begin
      list_reply_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         reply_taken = 1'b1;
         replies_taken++;
         if (replies_due.size() == 0) begin
            $display("%0t: response with none expected: read_value %0d count %0d status %0d",
                     $time, rsp_bus.read_value, rsp_bus.entry_count, rsp_bus.status);
            error_count++;
         end else begin
            want = replies_due.pop_front();
            if (rsp_bus.read_value !== want.read_value) begin
               $display("%0t: read_value mismatch: expected %0d, actual %0d",
                        $time, want.read_value, rsp_bus.read_value);
               error_count++;
            end
            if (rsp_bus.entry_count !== want.entry_count) begin
               $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                        $time, want.entry_count, rsp_bus.entry_count);
               error_count++;
            end
            if (rsp_bus.status !== want.status) begin
               $display("%0t: status mismatch: expected %0d, actual %0d",
                        $time, want.status, rsp_bus.status);
               error_count++;
            end
         end
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      int r;
      int past_full;
      int limit;

      // Directed: empty list, the end of the list, extreme values, unused mode.
      queue_op(MODE_READ, 0, 32'sd5);
      queue_op(MODE_INSERT, 1, 32'sd7);
      queue_op(MODE_UNUSED, 0, 32'sd9);
      queue_op(MODE_INSERT, 0, 32'sh7FFF_FFFF);
      queue_op(MODE_APPEND, 0, 32'sh8000_0000);
      queue_op(MODE_APPEND, 0, -32'sd1);
      queue_op(MODE_INSERT, 0, 32'sd0);
      queue_op(MODE_INSERT, 2, 32'sh5555_5555);
      queue_op(MODE_INSERT, 5, 32'shAAAA_AAAA);
      queue_op(MODE_INSERT, 7, 32'sd3);
      for (int i = 0; i < 6; i++) begin
         queue_op(MODE_READ, i, word_type'($urandom));
      end
      queue_op(MODE_READ, 6, 32'sd0);
      queue_op(MODE_READ, 255, word_type'($urandom));
      queue_op(MODE_UNUSED, 255, word_type'($urandom));
      queue_op(MODE_APPEND, 255, word_type'($urandom));

      // Random: grows the list to capacity, then keeps going on the full store.
      past_full = 0;
      for (int n = 0; n < RANDOM_OPS || planned_count < CAPACITY || past_full < 40; n++) begin
         r = $urandom_range(99, 0);
         if (r < 2) begin
            queue_op(MODE_UNUSED, $urandom_range(255, 0), word_type'($urandom));
         end else if (r < 20) begin
            queue_op(MODE_APPEND, $urandom_range(255, 0), word_type'($urandom));
         end else if (r < 38) begin
            limit = (planned_count > 255) ? 255 : planned_count;
            if ($urandom_range(9, 0) == 0) begin
               queue_op(MODE_INSERT, $urandom_range(255, 0), word_type'($urandom));
            end else begin
               queue_op(MODE_INSERT, $urandom_range(limit, 0), word_type'($urandom));
            end
         end else begin
            if (planned_count > 0 && $urandom_range(7, 0) != 0) begin
               queue_op(MODE_READ, $urandom_range(planned_count - 1, 0),
                        word_type'($urandom));
            end else begin
               queue_op(MODE_READ, $urandom_range(255, 0), word_type'($urandom));
            end
         end
         if (planned_count >= CAPACITY) begin
            past_full++;
         end
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (ops_accepted < ops_queued || replies_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
